@@ hdl/log_record_header_parser_core_macros.svh @@
// assertion helpers for the log record header parser
`ifndef LOG_RECORD_HEADER_PARSER_CORE_MACROS_SVH
`define LOG_RECORD_HEADER_PARSER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define LRHP_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LRHP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/lrhp_pkg.sv @@
`default_nettype none

package lrhp_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SHORT  = 2'd1,
    ST_UNSUP  = 2'd2
  } lrhp_status_t;

  typedef enum logic {
    CFG_BIG_ENDIAN = 1'b0,
    CFG_DOUBLED_ID = 1'b1
  } lrhp_cfg_index_t;

  localparam logic [1:0] KIND_NONE_UNSUP = 2'd0;
  localparam logic [1:0] KIND_SHORT      = 2'd2;
  localparam logic [1:0] KIND_LONG       = 2'd3;

  localparam logic [15:0] MIN_BYTES = 16'd4;
  localparam logic [15:0] COUNT_MAX = 16'hffff;

  typedef struct packed {
    logic [2:0] stamp_start;
    logic [2:0] stamp_len;
  } lrhp_layout_t;

  typedef struct packed {
    lrhp_status_t status;
    logic [13:0]  record_id;
    logic [5:0]   stamp_bits;
    logic [31:0]  stamp_value;
    logic [14:0]  payload_length;
    logic [3:0]   payload_offset;
    logic [15:0]  record_length;
  } lrhp_result_t;

  function automatic lrhp_layout_t layout(input logic [1:0] kind, input logic dbl);
    lrhp_layout_t l;
    unique case (kind)
      KIND_SHORT: begin
        l.stamp_start = dbl ? 3'd4 : 3'd2;
        l.stamp_len   = 3'd2;
      end
      KIND_LONG: begin
        l.stamp_start = 3'd2;
        l.stamp_len   = 3'd4;
      end
      default: begin
        l.stamp_start = 3'd2;
        l.stamp_len   = 3'd0;
      end
    endcase
    return l;
  endfunction

  // byte k of a two-byte word
  function automatic logic [15:0] place2(input logic k, input logic [7:0] b,
                                         input logic be);
    logic hi;
    hi = be ? !k : k;
    return hi ? {b, 8'h00} : {8'h00, b};
  endfunction

  // byte k of a four-byte word
  function automatic logic [31:0] place4(input logic [1:0] k, input logic [7:0] b,
                                         input logic be);
    logic [1:0] lane;
    lane = be ? (2'd3 - k) : k;
    return {24'h000000, b} << {lane, 3'b000};
  endfunction

endpackage

`default_nettype wire

@@ hdl/log_record_header_parser_core.sv @@
// log record header parser
// input stream: one buffer byte per transfer on s_tdata, s_tlast marks the
// final byte of the buffer. each byte updates the byte count and the header,
// stamp and count registers; one byte is taken per clock while s_tready is high.
// output stream: at most one result per buffer, produced by the byte that
// completes the record, by the fourth byte when the stamp kind is
// unsupported, or by the last byte when the buffer is too short. the result
// is registered into the output queue that drives m_tvalid.
// later bytes of the buffer up to s_tlast are dropped.
// results go through a two-entry output queue, so input is still taken while
// one result waits; s_tready is low while both entries are full, which only
// happens after the receiver has held m_tready low.
// cfg_wr_en/cfg_index/cfg_data write the byte order and doubled id options;
// they act on the next byte taken.
// rst (synchronous) clears the options, the parse state and the queue.
`default_nettype none

`include "log_record_header_parser_core_macros.svh"

module log_record_header_parser_core
  import lrhp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // record_id, stamp_bits, stamp_value, payload_length, payload_offset,
  // record_length, zero pad
  output logic [87:0]      m_tdata,
  output logic [1:0]       m_tuser    // status
);

  logic big_endian_order;
  logic doubled_short_id;

  logic [15:0] bytes_seen;
  logic [15:0] header_word;
  logic [31:0] stamp_store;
  logic [15:0] count_word;
  logic        record_reported;

  logic [15:0] bytes_seen_next;
  logic [15:0] header_word_next;
  logic [31:0] stamp_store_next;
  logic [15:0] count_word_next;
  logic        record_reported_next;

  lrhp_result_t res;
  logic         res_valid;

  lrhp_result_t q_data [2];
  logic [1:0]   count;

  logic accept;
  logic push;
  logic pop;
  logic wr_slot;

  assign accept = s_tvalid && s_tready;
  assign pop    = m_tvalid && m_tready;
  assign push   = accept && res_valid;

  assign s_tready = (count != 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign m_tuser  = q_data[0].status;
  assign m_tdata  = {1'b0,
                     q_data[0].record_length,
                     q_data[0].payload_offset,
                     q_data[0].payload_length,
                     q_data[0].stamp_value,
                     q_data[0].stamp_bits,
                     q_data[0].record_id};

  // per-byte parse
  always_comb begin
    lrhp_layout_t lo_cur;
    lrhp_layout_t lo_new;
    logic [15:0]  pos;
    logic [15:0]  ss;
    logic [15:0]  se;
    logic [15:0]  cs;
    logic [1:0]   k;
    logic [3:0]   pstart;
    logic [14:0]  plen;
    logic [15:0]  rec_len;
    logic         got_status;

    pos    = bytes_seen;
    lo_cur = layout(header_word[15:14], doubled_short_id);
    ss     = {13'd0, lo_cur.stamp_start};
    se     = ss + {13'd0, lo_cur.stamp_len};
    cs     = se;
    k      = pos[1:0] - lo_cur.stamp_start[1:0];

    header_word_next     = header_word;
    stamp_store_next     = stamp_store;
    count_word_next      = count_word;
    bytes_seen_next      = bytes_seen;
    record_reported_next = record_reported;
    res                  = '0;
    res_valid            = 1'b0;
    got_status           = 1'b0;
    lo_new               = '0;
    pstart               = '0;
    plen                 = '0;
    rec_len              = '0;

    if (record_reported) begin
      if (s_tlast) begin
        header_word_next     = '0;
        stamp_store_next     = '0;
        count_word_next      = '0;
        bytes_seen_next      = '0;
        record_reported_next = 1'b0;
      end
    end else begin
      if (pos < 16'd2) begin
        header_word_next = header_word | place2(pos[0], s_tdata, big_endian_order);
      end else if (header_word[15:14] != KIND_NONE_UNSUP) begin
        if (pos >= ss && pos < se) begin
          if (lo_cur.stamp_len == 3'd4) begin
            stamp_store_next = stamp_store | place4(k, s_tdata, big_endian_order);
          end else begin
            stamp_store_next = stamp_store |
                               {16'h0000, place2(k[0], s_tdata, big_endian_order)};
          end
        end else if (pos >= cs && pos < cs + 16'd2) begin
          count_word_next = count_word |
                            place2(pos[0] ^ cs[0], s_tdata, big_endian_order);
        end
      end

      bytes_seen_next = (pos != COUNT_MAX) ? pos + 16'd1 : pos;

      lo_new  = layout(header_word_next[15:14], doubled_short_id);
      pstart  = {1'b0, lo_new.stamp_start} + {1'b0, lo_new.stamp_len} + 4'd2;
      plen    = count_word_next[15] ? count_word_next[14:0]
                                    : {7'd0, count_word_next[15:8]};
      rec_len = {12'd0, pstart} + {1'b0, plen};

      if (bytes_seen_next >= MIN_BYTES) begin
        if (header_word_next[15:14] == KIND_NONE_UNSUP) begin
          got_status = 1'b1;
          res.status = ST_UNSUP;
        end else if (bytes_seen_next >= {12'd0, pstart} && bytes_seen_next >= rec_len) begin
          got_status         = 1'b1;
          res.status         = ST_OK;
          res.record_id      = header_word_next[13:0];
          res.stamp_bits     = {lo_new.stamp_len, 3'b000};
          res.stamp_value    = (lo_new.stamp_len != 3'd0) ? stamp_store_next : 32'd0;
          res.payload_length = plen;
          res.payload_offset = (plen == 15'd0) ? 4'd0 : pstart;
          res.record_length  = rec_len;
        end
      end

      if (!got_status && s_tlast) begin
        got_status = 1'b1;
        res        = '0;
        res.status = ST_SHORT;
      end

      res_valid = got_status;

      if (s_tlast) begin
        header_word_next     = '0;
        stamp_store_next     = '0;
        count_word_next      = '0;
        bytes_seen_next      = '0;
        record_reported_next = 1'b0;
      end else if (got_status) begin
        record_reported_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian_order <= 1'b0;
      doubled_short_id <= 1'b0;
      bytes_seen       <= '0;
      header_word      <= '0;
      stamp_store      <= '0;
      count_word       <= '0;
      record_reported  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (lrhp_cfg_index_t'(cfg_index))
          CFG_BIG_ENDIAN: big_endian_order <= cfg_data;
          CFG_DOUBLED_ID: doubled_short_id <= cfg_data;
        endcase
      end
      if (accept) begin
        bytes_seen      <= bytes_seen_next;
        header_word     <= header_word_next;
        stamp_store     <= stamp_store_next;
        count_word      <= count_word_next;
        record_reported <= record_reported_next;
      end
    end
  end

  // output queue, slot for a new entry after any pop of the head
  assign wr_slot = pop ? count[1] : count[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !wr_slot) begin
      q_data[0] <= res;
    end else if (pop) begin
      q_data[0] <= q_data[1];
    end
    if (push && wr_slot) begin
      q_data[1] <= res;
    end
  end

  `LRHP_ASSERT_NOW(a_reported_needs_header, record_reported, bytes_seen >= MIN_BYTES, "result flagged before four bytes")
  `LRHP_ASSERT_NEXT(a_last_clears, accept && s_tlast, bytes_seen == 16'd0 && !record_reported, "state not cleared after last byte")
  `LRHP_ASSERT_NOW(a_ok_has_length, m_tvalid && m_tuser == ST_OK, m_tdata[86:71] >= MIN_BYTES, "ok result with short record length")

endmodule

`default_nettype wire

@@ test/log_record_header_parser_core_tb.sv @@
`default_nettype none

module log_record_header_parser_core_tb;
  import lrhp_pkg::*;

  localparam logic [1:0] KIND_PLAIN = 2'd1;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_BYTES = 1250;
  localparam int PHASES = 6;

  // parses bytes the way the block should and holds the headers still due
  class header_tracker;
    bit be_order;
    bit dbl_id;
    bit [15:0] seen;
    bit [15:0] hdr;
    bit [31:0] stamp;
    bit [15:0] cnt;
    bit reported;
    lrhp_result_t expected_headers[$];
    int errors;

    function void set_option(lrhp_cfg_index_t idx, bit v);
      if (idx == CFG_BIG_ENDIAN) be_order = v;
      else dbl_id = v;
    endfunction

    function void clear_buffer();
      seen = 0;
      hdr = 0;
      stamp = 0;
      cnt = 0;
      reported = 0;
    endfunction

    function bit [31:0] lane_byte(bit [7:0] b, int k, int size);
      int sh;
      sh = be_order ? 8 * (size - 1 - k) : 8 * k;
      return 32'(b) << sh;
    endfunction

    function void stamp_span(bit [1:0] kind, output int start, output int len);
      start = 2;
      len = 0;
      if (kind == KIND_SHORT) begin
        start = dbl_id ? 4 : 2;
        len = 2;
      end else if (kind == KIND_LONG) begin
        len = 4;
      end
    endfunction

    function void take_byte(bit [7:0] b, bit last);
      int pos;
      int ss;
      int sl;
      int cs;
      int pstart;
      int plen;
      bit [1:0] kind;
      bit hit;
      lrhp_result_t r;
      if (reported) begin
        if (last) clear_buffer();
        return;
      end
      pos = seen;
      kind = hdr[15:14];
      if (pos < 2) begin
        hdr = hdr | 16'(lane_byte(b, pos, 2));
      end else if (kind != KIND_NONE_UNSUP) begin
        stamp_span(kind, ss, sl);
        cs = ss + sl;
        if (pos >= ss && pos < ss + sl) stamp = stamp | lane_byte(b, pos - ss, sl);
        else if (pos >= cs && pos < cs + 2) cnt = cnt | 16'(lane_byte(b, pos - cs, 2));
      end
      if (seen != 16'hffff) seen = seen + 1;
      kind = hdr[15:14];
      r = '0;
      hit = 0;
      if (seen >= 4) begin
        if (kind == KIND_NONE_UNSUP) begin
          r.status = ST_UNSUP;
          hit = 1;
        end else begin
          stamp_span(kind, ss, sl);
          pstart = ss + sl + 2;
          if (int'(seen) >= pstart) begin
            plen = cnt[15] ? int'(cnt[14:0]) : int'(cnt[15:8]);
            if (int'(seen) >= pstart + plen) begin
              r.status = ST_OK;
              r.record_id = hdr[13:0];
              r.stamp_bits = 6'(8 * sl);
              r.stamp_value = (sl != 0) ? stamp : 32'd0;
              r.payload_length = 15'(plen);
              r.payload_offset = (plen == 0) ? 4'd0 : 4'(pstart);
              r.record_length = 16'(pstart + plen);
              hit = 1;
            end
          end
        end
      end
      if (!hit && last) begin
        r = '0;
        r.status = ST_SHORT;
        hit = 1;
      end
      if (last) clear_buffer();
      if (hit) begin
        expected_headers.push_back(r);
        if (!last) reported = 1;
      end
    endfunction

    function void field_diff(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void match_header(logic [87:0] d, logic [1:0] st);
      lrhp_result_t e;
      if (expected_headers.size() == 0) begin
        $display("%0t unexpected result: expected none, actual status %0h data %0h",
                 $time, st, d);
        errors++;
        return;
      end
      e = expected_headers.pop_front();
      field_diff("status", 32'(e.status), 32'(st));
      field_diff("record_id", 32'(e.record_id), 32'(d[13:0]));
      field_diff("stamp_bits", 32'(e.stamp_bits), 32'(d[19:14]));
      field_diff("stamp_value", e.stamp_value, d[51:20]);
      field_diff("payload_length", 32'(e.payload_length), 32'(d[66:52]));
      field_diff("payload_offset", 32'(e.payload_offset), 32'(d[70:67]));
      field_diff("record_length", 32'(e.record_length), 32'(d[86:71]));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = 1'b0;
  logic cfg_data = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic [1:0] m_tuser;

  header_tracker tracker = new();
  int cycle_count = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit cfg_be = 1'b0;
  bit cfg_dbl = 1'b0;
  bit [7:0] frame_q[$];
  int sent_bytes = 0;

  log_record_header_parser_core u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else if (!rst) begin
      if (s_tvalid && s_tready) tracker.take_byte(s_tdata, s_tlast);
      if (cfg_wr_en) tracker.set_option(lrhp_cfg_index_t'(cfg_index), cfg_data);
      if (m_tvalid && m_tready) tracker.match_header(m_tdata, m_tuser);
    end
  end

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  function automatic void push_word(bit [31:0] v, int size);
    for (int k = 0; k < size; k++)
      frame_q.push_back(cfg_be ? v[8 * (size - 1 - k) +: 8] : v[8 * k +: 8]);
  endfunction

  function automatic void build_record(bit [1:0] kind, bit [13:0] id, bit [31:0] stamp,
                                       bit [15:0] cword, int extra);
    int plen;
    frame_q.delete();
    push_word({kind, id}, 2);
    if (kind == KIND_SHORT) begin
      if (cfg_dbl) push_word($urandom, 2);
      push_word(stamp, 2);
    end else if (kind == KIND_LONG) begin
      push_word(stamp, 4);
    end
    push_word(cword, 2);
    plen = cword[15] ? int'(cword[14:0]) : int'(cword[15:8]);
    repeat (plen + extra) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void cut_frame(int n);
    frame_q = frame_q[0:n-1];
  endfunction

  function automatic bit [15:0] rand_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return {1'b1, 15'($urandom_range(0, 12))};
      4, 5, 6, 7: return {8'($urandom_range(0, 12)), 8'($urandom)};
      8: return {8'($urandom_range(0, 127)), 8'($urandom)};
      default: return {1'b1, 15'($urandom_range(13, 300))};
    endcase
  endfunction

  task automatic send_byte(bit [7:0] b, bit last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.expected_headers.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_options(bit be, bit dbl);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_BIG_ENDIAN;
    cfg_data <= be;
    @(posedge clk);
    cfg_index <= CFG_DOUBLED_ID;
    cfg_data <= dbl;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_be = be;
    cfg_dbl = dbl;
  endtask

  task automatic rand_buffer();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 9) begin
      frame_q.delete();
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
    end else begin
      build_record((pick == 8) ? KIND_NONE_UNSUP : 2'($urandom_range(1, 3)),
                   14'($urandom), $urandom, rand_count(),
                   $urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
      if (pick >= 7) cut_frame($urandom_range(1, frame_q.size()));
    end
    send_frame();
    sent_bytes += frame_q.size();
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty payload, widest stamp, length from high byte with trailing bytes
    build_record(KIND_PLAIN, 14'h3fff, 32'd0, 16'h8000, 0);
    send_frame();
    build_record(KIND_LONG, 14'h0000, 32'hffffffff, 16'h8003, 0);
    send_frame();
    build_record(KIND_SHORT, 14'h2aaa, 32'h0000a55a, 16'h02ff, 2);
    send_frame();
    build_record(KIND_PLAIN, 14'h1555, 32'd0, 16'h00ff, 0);
    send_frame();
    // unsupported kind, then unsupported kind cut before the fourth byte
    build_record(KIND_NONE_UNSUP, 14'h3fff, 32'd0, 16'h8000, 3);
    send_frame();
    build_record(KIND_NONE_UNSUP, 14'h0000, 32'd0, 16'h8000, 0);
    cut_frame(3);
    send_frame();
    // short buffers
    frame_q = '{8'hff};
    send_frame();
    frame_q = '{8'h00, 8'h40};
    send_frame();
    build_record(KIND_LONG, 14'h0123, 32'h12345678, 16'h8005, 0);
    cut_frame(7);
    send_frame();
    drain();

    set_options(1'b1, 1'b1);
    build_record(KIND_SHORT, 14'h0f0f, 32'h0000ffff, 16'h8002, 1);
    send_frame();
    build_record(KIND_LONG, 14'h3c3c, 32'h89abcdef, 16'h0400, 0);
    send_frame();
    build_record(KIND_PLAIN, 14'h0001, 32'd0, 16'h8001, 0);
    send_frame();
    build_record(KIND_NONE_UNSUP, 14'h2222, 32'd0, 16'h8000, 0);
    send_frame();
    drain();

    set_options(1'b0, 1'b1);
    build_record(KIND_SHORT, 14'h1234, 32'h0000beef, 16'h8000, 0);
    send_frame();
    drain();

    // payload length from the high byte, then a long payload with a 15-bit count
    set_options(1'b1, 1'b0);
    build_record(KIND_SHORT, 14'h0abc, 32'h00001234, 16'h0100, 0);
    send_frame();
    build_record(KIND_LONG, 14'($urandom), $urandom, 16'h812c, 0);
    send_frame();
    drain();

    // receiver stalls long while short records keep coming
    hold_req = 1'b1;
    repeat (12) begin
      build_record(KIND_PLAIN, 14'($urandom), 32'd0, 16'h8000, 0);
      send_frame();
    end
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_options(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      idle_on = (ph != PHASES - 1);
      target = RANDOM_BYTES * (ph + 1) / PHASES;
      while (sent_bytes < target) rand_buffer();
      drain();
    end

    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_headers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ log_record_header_parser_core.f @@
+incdir+hdl
hdl/lrhp_pkg.sv
hdl/log_record_header_parser_core.sv
test/log_record_header_parser_core_tb.sv
